[rtl/mcae_pkg.sv]
// shared widths, codes and control types of the media clock anchor engine
package mcae_pkg;

  localparam int TIME_W    = 48;
  localparam int RATE_FRAC = 16;
  localparam int RATE_W    = RATE_FRAC + 4;
  localparam int WIN_W     = 24;
  localparam int FUNC_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_AW    = 1;

  localparam int MAG_W   = TIME_W + 1;
  localparam int PROD_W  = MAG_W + RATE_W;
  localparam int PSUM_W  = PROD_W - RATE_FRAC + 2;
  localparam int DVD_W   = MAG_W + RATE_FRAC;
  localparam int DSUM_W  = DVD_W + 3;
  localparam int MCNT_W  = $clog2(RATE_W + 1);
  localparam int DCNT_W  = $clog2(DVD_W + 1);

  localparam int IN_DATA_W  = ((5 * TIME_W + RATE_W + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TIME_W + RATE_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_UPDATE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET_MAX = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_RATE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_MEDIA_Q = 3'd4;
  localparam logic [FUNC_W-1:0] FN_REAL_Q  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ANCH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_FLUCT    = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_START  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_WINDOW = 1'b1;

  localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic signed [TIME_W-1:0] TIME_NEG1 = {TIME_W{1'b1}};
  localparam logic [RATE_W-1:0] RATE_ONE   = RATE_W'(1 << RATE_FRAC);
  localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(10000);

  typedef struct packed {
    logic              item_load;
    logic              mul_start;
    logic              mul_sel;
    logic              nm_capture;
    logic              max_upd;
    logic              clear_anchor;
    logic              set_max;
    logic              commit;
    logic              commit_nm;
    logic              reanchor;
    logic              set_rate;
    logic              time_clear;
    logic              time_media;
    logic              med_load;
    logic              div_start;
    logic              time_div;
    logic              out_load;
    logic [STAT_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_anchor_neg;
    logic              has_anchor;
    logic              rate_zero;
    logic              mul_busy;
    logic              proj_neg;
    logic              fluct;
    logic              div_busy;
  } dp_sts_t;

endpackage

[rtl/mcae_ctrl.sv]
// command sequencer of the media clock anchor engine
module mcae_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  mcae_pkg::dp_sts_t sts,
  output mcae_pkg::dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_USE1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_USE2 = 4'd5;
  localparam logic [3:0] S_DIVS = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [mcae_pkg::STAT_W-1:0] st_r, st_nxt;
  logic                        out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.status = st_r;
    cmd.item_load = in_tvalid && (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISP;
      end
      S_DISP: begin
        cmd.time_clear = 1'b1;
        st_nxt = mcae_pkg::ST_OK;
        state_nxt = S_DONE;
        case (sts.func)
          mcae_pkg::FN_CLEAR: cmd.clear_anchor = 1'b1;
          mcae_pkg::FN_UPDATE: begin
            if (sts.in_anchor_neg) begin
              st_nxt = mcae_pkg::ST_REJECTED;
            end else begin
              cmd.mul_start = 1'b1;
              state_nxt = S_MUL1;
            end
          end
          mcae_pkg::FN_SET_MAX: cmd.set_max = 1'b1;
          mcae_pkg::FN_SET_RATE: begin
            if (sts.has_anchor) begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel = 1'b1;
              state_nxt = S_MUL1;
            end else begin
              cmd.set_rate = 1'b1;
            end
          end
          mcae_pkg::FN_MEDIA_Q: begin
            if (!sts.has_anchor) begin
              st_nxt = mcae_pkg::ST_NO_ANCH;
            end else begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel = 1'b1;
              state_nxt = S_MUL1;
            end
          end
          mcae_pkg::FN_REAL_Q: begin
            if (sts.rate_zero || !sts.has_anchor) begin
              st_nxt = mcae_pkg::ST_NO_ANCH;
            end else begin
              cmd.mul_start = 1'b1;
              cmd.mul_sel = 1'b1;
              state_nxt = S_MUL1;
            end
          end
          default: st_nxt = mcae_pkg::ST_OK;
        endcase
      end
      S_MUL1: begin
        if (!sts.mul_busy) state_nxt = S_USE1;
      end
      S_USE1: begin
        state_nxt = S_DONE;
        case (sts.func)
          mcae_pkg::FN_UPDATE: begin
            if (sts.proj_neg) begin
              st_nxt = mcae_pkg::ST_REJECTED;
            end else begin
              cmd.nm_capture = 1'b1;
              cmd.max_upd = 1'b1;
              if (sts.has_anchor) begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel = 1'b1;
                state_nxt = S_MUL2;
              end else begin
                cmd.commit = 1'b1;
              end
            end
          end
          mcae_pkg::FN_SET_RATE: begin
            cmd.reanchor = 1'b1;
            cmd.set_rate = 1'b1;
          end
          mcae_pkg::FN_MEDIA_Q: cmd.time_media = 1'b1;
          mcae_pkg::FN_REAL_Q: begin
            cmd.med_load = 1'b1;
            state_nxt = S_DIVS;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MUL2: begin
        if (!sts.mul_busy) state_nxt = S_USE2;
      end
      S_USE2: begin
        // backward step inside the window keeps the old anchor
        if (sts.fluct) begin
          st_nxt = mcae_pkg::ST_FLUCT;
        end else begin
          cmd.commit = 1'b1;
          cmd.commit_nm = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.time_div = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= mcae_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/mcae_dp.sv]
// datapath: clock state, serial projection multiplier and serial divider
module mcae_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mcae_pkg::dp_cmd_t                   cmd,
  output mcae_pkg::dp_sts_t                   sts,
  input  logic                                cfg_we,
  input  logic [mcae_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [mcae_pkg::TIME_W-1:0]         cfg_wdata,
  input  logic [mcae_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [mcae_pkg::TIME_W-1:0]  in_now,
  input  logic signed [mcae_pkg::TIME_W-1:0]  in_anchor_media,
  input  logic signed [mcae_pkg::TIME_W-1:0]  in_anchor_real,
  input  logic signed [mcae_pkg::TIME_W-1:0]  in_max_media,
  input  logic [mcae_pkg::RATE_W-1:0]         in_new_rate,
  input  logic                                in_allow_past_max,
  input  logic signed [mcae_pkg::TIME_W-1:0]  in_target_media,
  output logic [mcae_pkg::STAT_W-1:0]         out_status,
  output logic signed [mcae_pkg::TIME_W-1:0]  out_time,
  output logic [mcae_pkg::RATE_W-1:0]         out_rate_now
);

  localparam int TW = mcae_pkg::TIME_W;
  localparam int RW = mcae_pkg::RATE_W;

  // latched item
  logic [mcae_pkg::FUNC_W-1:0] func_r;
  logic signed [TW-1:0] now_r, am_in_r, ar_in_r, mx_r, target_r;
  logic [RW-1:0] nrate_r;
  logic allow_r;

  // clock state and configuration
  logic signed [TW-1:0] anc_media_r, anc_real_r, max_r, start_r;
  logic [RW-1:0] rate_r;
  logic [mcae_pkg::WIN_W-1:0] win_r;

  // multiplier
  logic msel_r, mneg_r;
  logic [mcae_pkg::MAG_W-1:0] mcand_r;
  logic [RW-1:0] mr_r;
  logic [mcae_pkg::PROD_W-1:0] acc_r;
  logic [mcae_pkg::MCNT_W-1:0] mcnt_r;
  logic signed [TW-1:0] proj_r, nm_r, med_r, time_r;

  // divider
  logic dneg_r;
  logic [mcae_pkg::DVD_W-1:0] dvd_r;
  logic [RW-1:0] drem_r;
  logic [mcae_pkg::DCNT_W-1:0] dcnt_r;

  logic [mcae_pkg::STAT_W-1:0] ostat_r;
  logic signed [TW-1:0] otime_r;
  logic [RW-1:0] orate_r;

  function automatic logic signed [TW-1:0] media_at(
    input logic signed [TW-1:0] m,
    input logic                 allow,
    input logic signed [TW-1:0] mx,
    input logic signed [TW-1:0] st
  );
    logic signed [TW-1:0] r;
    r = m;
    if (r > mx && !allow) r = mx;
    if (r < st) r = st;
    if (r < 0) r = '0;
    return r;
  endfunction

  // projection operands
  logic signed [TW-1:0] p_base, p_ref;
  logic signed [TW:0] p_diff;
  logic [mcae_pkg::MAG_W-1:0] p_mag;
  logic [mcae_pkg::PROD_W-1:0] acc_nxt;
  logic signed [mcae_pkg::PSUM_W-1:0] p_bx, p_px, p_sum;
  logic signed [TW-1:0] proj_nxt;

  assign p_base = msel_r ? anc_media_r : am_in_r;
  assign p_ref  = msel_r ? anc_real_r : ar_in_r;
  assign p_diff = {now_r[TW-1], now_r} - {p_ref[TW-1], p_ref};
  assign p_mag  = p_diff[TW] ? mcae_pkg::MAG_W'(-p_diff) : mcae_pkg::MAG_W'(p_diff);
  assign acc_nxt = {acc_r[mcae_pkg::PROD_W-2:0], 1'b0}
                 + (mr_r[RW-1] ? mcae_pkg::PROD_W'(mcand_r) : '0);

  always_comb begin
    p_bx  = mcae_pkg::PSUM_W'(p_base);
    p_px  = $signed({2'b00, acc_r[mcae_pkg::PROD_W-1:mcae_pkg::RATE_FRAC]});
    p_sum = mneg_r ? p_bx - p_px : p_bx + p_px;
    if (p_sum > mcae_pkg::PSUM_W'(mcae_pkg::TIME_MAX)) proj_nxt = mcae_pkg::TIME_MAX;
    else if (p_sum < mcae_pkg::PSUM_W'(mcae_pkg::TIME_MIN)) proj_nxt = mcae_pkg::TIME_MIN;
    else proj_nxt = p_sum[TW-1:0];
  end

  // fluctuation window test against the old projection
  logic signed [TW:0] low_w;
  logic signed [TW-1:0] low;
  assign low_w = {proj_r[TW-1], proj_r} - $signed({1'b0, (TW)'(win_r)});
  assign low = (low_w < (TW+1)'(mcae_pkg::TIME_MIN)) ? mcae_pkg::TIME_MIN : low_w[TW-1:0];

  // divider step and final sum
  logic [RW:0] d_try;
  logic d_ge;
  logic signed [TW:0] d_diff;
  logic [mcae_pkg::DVD_W:0] d_q;
  logic signed [mcae_pkg::DSUM_W-1:0] d_nx, d_qx, d_sum;
  logic signed [TW-1:0] div_res;

  assign d_try  = {drem_r, dvd_r[mcae_pkg::DVD_W-1]};
  assign d_ge   = d_try >= {1'b0, rate_r};
  assign d_diff = {target_r[TW-1], target_r} - {med_r[TW-1], med_r};

  always_comb begin
    // floor for negative quotients
    d_q   = {1'b0, dvd_r} + (mcae_pkg::DVD_W+1)'(dneg_r && (drem_r != '0));
    d_nx  = mcae_pkg::DSUM_W'(now_r);
    d_qx  = $signed({2'b00, d_q});
    d_sum = dneg_r ? d_nx - d_qx : d_nx + d_qx;
    if (d_sum > mcae_pkg::DSUM_W'(mcae_pkg::TIME_MAX)) div_res = mcae_pkg::TIME_MAX;
    else if (d_sum < mcae_pkg::DSUM_W'(mcae_pkg::TIME_MIN)) div_res = mcae_pkg::TIME_MIN;
    else div_res = d_sum[TW-1:0];
  end

  assign sts.func          = func_r;
  assign sts.in_anchor_neg = am_in_r[TW-1] | ar_in_r[TW-1];
  assign sts.has_anchor    = (anc_real_r != mcae_pkg::TIME_NEG1);
  assign sts.rate_zero     = (rate_r == '0);
  assign sts.mul_busy      = (mcnt_r != '0);
  assign sts.proj_neg      = proj_r[TW-1];
  assign sts.fluct         = (nm_r < proj_r) && (nm_r > low);
  assign sts.div_busy      = (dcnt_r != '0);

  assign out_status   = ostat_r;
  assign out_time     = otime_r;
  assign out_rate_now = orate_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      func_r   <= in_func;
      now_r    <= in_now;
      am_in_r  <= in_anchor_media;
      ar_in_r  <= in_anchor_real;
      mx_r     <= in_max_media;
      nrate_r  <= in_new_rate;
      allow_r  <= in_allow_past_max;
      target_r <= in_target_media;
    end
    proj_r <= proj_nxt;
    if (cmd.mul_start) begin
      msel_r <= cmd.mul_sel;
    end
    if (cmd.nm_capture) nm_r <= proj_r;
    if (cmd.med_load) med_r <= media_at(proj_r, 1'b1, max_r, start_r);
    if (cmd.time_clear) time_r <= '0;
    else if (cmd.time_media) time_r <= media_at(proj_r, allow_r, max_r, start_r);
    else if (cmd.time_div) time_r <= div_res;
    if (cmd.out_load) begin
      ostat_r <= cmd.status;
      otime_r <= time_r;
      orate_r <= rate_r;
    end
  end

  // multiplier operands are taken in the cycle after the select is set
  logic mload_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mload_r <= 1'b0;
      mcnt_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      mload_r <= cmd.mul_start;
      if (cmd.mul_start) mcnt_r <= mcae_pkg::MCNT_W'(RW + 1);
      else if (mcnt_r != '0) mcnt_r <= mcnt_r - 1'b1;
      if (cmd.div_start) dcnt_r <= mcae_pkg::DCNT_W'(mcae_pkg::DVD_W);
      else if (dcnt_r != '0) dcnt_r <= dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mload_r) begin
      mneg_r  <= p_diff[TW];
      mcand_r <= p_mag;
      mr_r    <= rate_r;
      acc_r   <= '0;
    end else if (mcnt_r != '0) begin
      acc_r <= acc_nxt;
      mr_r  <= {mr_r[RW-2:0], 1'b0};
    end
    if (cmd.div_start) begin
      dneg_r <= d_diff[TW];
      dvd_r  <= {(d_diff[TW] ? mcae_pkg::MAG_W'(-d_diff) : mcae_pkg::MAG_W'(d_diff)),
                 {mcae_pkg::RATE_FRAC{1'b0}}};
      drem_r <= '0;
    end else if (dcnt_r != '0) begin
      drem_r <= d_ge ? RW'(d_try - {1'b0, rate_r}) : d_try[RW-1:0];
      dvd_r  <= {dvd_r[mcae_pkg::DVD_W-2:0], d_ge};
    end
  end

  // clock state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anc_media_r <= mcae_pkg::TIME_NEG1;
      anc_real_r  <= mcae_pkg::TIME_NEG1;
      max_r       <= mcae_pkg::TIME_MAX;
      rate_r      <= mcae_pkg::RATE_ONE;
      start_r     <= mcae_pkg::TIME_NEG1;
      win_r       <= mcae_pkg::WIN_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mcae_pkg::CFG_START:  start_r <= cfg_wdata;
          mcae_pkg::CFG_WINDOW: win_r <= cfg_wdata[mcae_pkg::WIN_W-1:0];
          default: win_r <= win_r;
        endcase
      end
      if (cmd.clear_anchor) begin
        anc_media_r <= mcae_pkg::TIME_NEG1;
        anc_real_r  <= mcae_pkg::TIME_NEG1;
      end else if (cmd.commit) begin
        anc_media_r <= cmd.commit_nm ? nm_r : proj_r;
        anc_real_r  <= now_r;
      end else if (cmd.reanchor) begin
        anc_media_r <= proj_r[TW-1] ? '0 : proj_r;
        anc_real_r  <= now_r;
      end
      if (cmd.set_max) max_r <= mx_r;
      else if (cmd.max_upd && (mx_r != mcae_pkg::TIME_NEG1)) max_r <= mx_r;
      if (cmd.set_rate) rate_r <= nrate_r;
    end
  end

endmodule

[rtl/media_clock_anchor_engine.sv]
// top level of the media clock anchor engine
// Usage: each command item on the in_ channel (kind in in_tuser) gives exactly
// one result item on the out_ channel (status in out_tuser, time and current
// rate in out_tdata). The cfg_ port writes the start-time clamp (index 0) and
// the fluctuation window (index 1); the user must write them only while the
// block is idle, which the block does not enforce. Clear, set max, set rate
// without an anchor and unused commands need no arithmetic; set rate with an
// anchor and media queries run one projection, real-time queries one and a
// division, anchor updates up to two. Each projection runs a bit-serial
// multiplier over the 20 rate bits; the reverse query adds a restoring divider
// that makes one quotient bit per cycle over 65 bits. One item is processed at
// a time; in_tready is high only while the sequencer is idle.
// A finished result sits in an output register, so a new item may be accepted
// while the receiver stalls; the next result then waits until that slot frees.
// Reset (rst_n low at a clock edge) removes the anchor, sets the maximum to the
// largest time, the rate to normal speed, the start clamp to -1 and the window
// to 10000, and drops any pending result.
module media_clock_anchor_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_us, anchor_media_us, anchor_real_us, max_media_us, new_rate,
  // allow_past_max, target_media_us, zero pad
  input  logic [mcae_pkg::IN_DATA_W-1:0]      in_tdata,
  // func
  input  logic [mcae_pkg::FUNC_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // time_us, rate_now, zero pad
  output logic [mcae_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [mcae_pkg::STAT_W-1:0]         out_tuser,
  input  logic                                cfg_we,
  input  logic [mcae_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [mcae_pkg::TIME_W-1:0]         cfg_wdata
);

  localparam int TW = mcae_pkg::TIME_W;
  localparam int RW = mcae_pkg::RATE_W;

  mcae_pkg::dp_cmd_t cmd;
  mcae_pkg::dp_sts_t sts;
  logic signed [TW-1:0] out_time;
  logic [RW-1:0] out_rate;

  mcae_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mcae_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_tuser),
    .in_now            (in_tdata[TW-1:0]),
    .in_anchor_media   (in_tdata[2*TW-1:TW]),
    .in_anchor_real    (in_tdata[3*TW-1:2*TW]),
    .in_max_media      (in_tdata[4*TW-1:3*TW]),
    .in_new_rate       (in_tdata[4*TW+RW-1:4*TW]),
    .in_allow_past_max (in_tdata[4*TW+RW]),
    .in_target_media   (in_tdata[5*TW+RW:4*TW+RW+1]),
    .out_status        (out_tuser),
    .out_time          (out_time),
    .out_rate_now      (out_rate)
  );

  assign out_tdata = {{(mcae_pkg::OUT_DATA_W - TW - RW){1'b0}}, out_rate, out_time};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("engine accepted a second item without finishing the first");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.mul_busy && sts.div_busy))
    else $error("multiplier and divider active together");

  a_time_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != mcae_pkg::ST_OK) |-> (out_tdata[TW-1:0] == '0))
    else $error("non-zero time on a failed command");

  a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready || $past(cmd.out_load))
    else $error("result raised without a command");

endmodule

[sim/tb_media_clock_anchor_engine.sv]
// self-checking testbench of the media clock anchor engine
`timescale 1ns / 100ps

module tb_media_clock_anchor_engine;

  localparam longint TMAXL = 64'sh7FFF_FFFF_FFFF;
  localparam longint TMINL = -TMAXL - 1;
  localparam int     N_PHASE = 8;
  localparam int     N_RAND  = 230;

  typedef struct {
    logic [mcae_pkg::FUNC_W-1:0] func;
    logic [mcae_pkg::TIME_W-1:0] now, am, ar, mx, tgt;
    logic [mcae_pkg::RATE_W-1:0] nr;
    logic                        allow;
  } cmd_t;

  typedef struct {
    logic [mcae_pkg::STAT_W-1:0] status;
    logic [mcae_pkg::TIME_W-1:0] t;
    logic [mcae_pkg::RATE_W-1:0] rate;
  } res_t;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t e;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [mcae_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [mcae_pkg::FUNC_W-1:0]     in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mcae_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [mcae_pkg::STAT_W-1:0]     out_tuser;
  logic                            cfg_we = 1'b0;
  logic [mcae_pkg::CFG_AW-1:0]     cfg_addr = '0;
  logic [mcae_pkg::TIME_W-1:0]     cfg_wdata = '0;

  media_clock_anchor_engine u_dut (.*);

  always #6 clk = ~clk;

  // predictor state
  longint                      anc_media, anc_real, max_media, start_clamp;
  logic [mcae_pkg::RATE_W-1:0] play_rate;
  logic [mcae_pkg::WIN_W-1:0]  fluct_win;

  res_t   pending_results[$];
  int     n_errors = 0;
  int     idle_mode = 0;
  longint wall_now = 1000;
  row_t   rows[$];

  function automatic longint sat48(logic signed [127:0] v);
    if (v > 128'(TMAXL)) return TMAXL;
    if (v < 128'(TMINL)) return TMINL;
    return longint'(v[63:0]);
  endfunction

  function automatic longint project(longint base, longint t, longint rf,
                                     logic [mcae_pkg::RATE_W-1:0] r);
    logic signed [127:0] d, m, q;
    d = 128'(t) - 128'(rf);
    m = (d < 0) ? -d : d;
    q = (m * $signed({108'b0, r})) >>> mcae_pkg::RATE_FRAC;
    return sat48((d < 0) ? 128'(base) - q : 128'(base) + q);
  endfunction

  function automatic longint media_at(longint t, bit allow);
    longint m;
    m = project(anc_media, t, anc_real, play_rate);
    if (m > max_media && !allow) m = max_media;
    if (m < start_clamp) m = start_clamp;
    if (m < 0) m = 0;
    return m;
  endfunction

  function automatic longint real_for(longint tgt, longint media, longint now);
    logic signed [127:0] d, m, q, rm, rr;
    rr = $signed({108'b0, play_rate});
    d = 128'(tgt) - 128'(media);
    m = (d < 0) ? -d : d;
    m = m <<< mcae_pkg::RATE_FRAC;
    q = m / rr;
    rm = m % rr;
    if (d < 0 && rm != 0) q = q + 1;
    return sat48((d < 0) ? 128'(now) - q : 128'(now) + q);
  endfunction

  function automatic res_t predict(cmd_t c);
    res_t   r;
    longint now, am, ar, mx, tg, nm, old, low;
    now = longint'($signed(c.now));
    am = longint'($signed(c.am));
    ar = longint'($signed(c.ar));
    mx = longint'($signed(c.mx));
    tg = longint'($signed(c.tgt));
    r.status = mcae_pkg::ST_OK;
    r.t = '0;
    case (c.func)
      mcae_pkg::FN_CLEAR: begin
        anc_media = -1;
        anc_real = -1;
      end
      mcae_pkg::FN_UPDATE: begin
        nm = 0;
        if (am < 0 || ar < 0) r.status = mcae_pkg::ST_REJECTED;
        else begin
          nm = project(am, now, ar, play_rate);
          if (nm < 0) r.status = mcae_pkg::ST_REJECTED;
        end
        if (r.status == mcae_pkg::ST_OK) begin
          if (mx != -1) max_media = mx;
          if (anc_real != -1) begin
            old = project(anc_media, now, anc_real, play_rate);
            low = sat48(128'(old) - 128'(fluct_win));
            if (nm < old && nm > low) r.status = mcae_pkg::ST_FLUCT;
          end
          if (r.status == mcae_pkg::ST_OK) begin
            anc_real = now;
            anc_media = nm;
          end
        end
      end
      mcae_pkg::FN_SET_MAX: max_media = mx;
      mcae_pkg::FN_SET_RATE: begin
        if (anc_real != -1) begin
          anc_media = project(anc_media, now, anc_real, play_rate);
          if (anc_media < 0) anc_media = 0;
          anc_real = now;
        end
        play_rate = c.nr;
      end
      mcae_pkg::FN_MEDIA_Q: begin
        if (anc_real == -1) r.status = mcae_pkg::ST_NO_ANCH;
        else r.t = mcae_pkg::TIME_W'(media_at(now, c.allow));
      end
      mcae_pkg::FN_REAL_Q: begin
        if (play_rate == 0 || anc_real == -1) r.status = mcae_pkg::ST_NO_ANCH;
        else r.t = mcae_pkg::TIME_W'(real_for(tg, media_at(now, 1'b1), now));
      end
      default: ;
    endcase
    r.rate = play_rate;
    return r;
  endfunction

  function automatic logic [mcae_pkg::TIME_W-1:0] rand48();
    return mcae_pkg::TIME_W'({$urandom, $urandom});
  endfunction

  function automatic cmd_t mk(logic [mcae_pkg::FUNC_W-1:0] f, longint now, longint am,
                              longint ar, longint mx, logic [mcae_pkg::RATE_W-1:0] nr,
                              bit allow, longint tgt);
    cmd_t c;
    c.func = f;
    c.now = mcae_pkg::TIME_W'(now);
    c.am = mcae_pkg::TIME_W'(am);
    c.ar = mcae_pkg::TIME_W'(ar);
    c.mx = mcae_pkg::TIME_W'(mx);
    c.nr = nr;
    c.allow = allow;
    c.tgt = mcae_pkg::TIME_W'(tgt);
    return c;
  endfunction

  // unused function codes above the real-time query
  function automatic logic [mcae_pkg::FUNC_W-1:0] FN_FUNC_X();
    return mcae_pkg::FN_REAL_Q + mcae_pkg::FUNC_W'($urandom_range(2, 1));
  endfunction

  function automatic cmd_t gen_cmd();
    cmd_t   c;
    int     k;
    longint base;
    c.now = rand48();
    c.am = rand48();
    c.ar = rand48();
    c.mx = rand48();
    c.tgt = rand48();
    c.nr = mcae_pkg::RATE_W'($urandom);
    c.allow = 1'($urandom_range(1));
    k = int'($urandom_range(99));
    if (k < 5) c.func = mcae_pkg::FN_CLEAR;
    else if (k < 33) c.func = mcae_pkg::FN_UPDATE;
    else if (k < 40) c.func = mcae_pkg::FN_SET_MAX;
    else if (k < 50) c.func = mcae_pkg::FN_SET_RATE;
    else if (k < 72) c.func = mcae_pkg::FN_MEDIA_Q;
    else if (k < 95) c.func = mcae_pkg::FN_REAL_Q;
    else c.func = FN_FUNC_X();
    // broken or noisy items keep their random fields
    if ($urandom_range(99) < 12) return c;
    wall_now += longint'($urandom_range(200000));
    if (wall_now > 64'sd70_000_000_000_000 || $urandom_range(99) == 0)
      wall_now = longint'($urandom_range(1000000));
    c.now = mcae_pkg::TIME_W'(wall_now);
    c.ar = mcae_pkg::TIME_W'(wall_now - longint'($urandom_range(100000)));
    if (c.ar[mcae_pkg::TIME_W-1]) c.ar = '0;
    c.am = mcae_pkg::TIME_W'(longint'($urandom_range(32'h3FFF_FFFF)));
    if (c.func == mcae_pkg::FN_UPDATE && anc_real != -1 && $urandom_range(99) < 35) begin
      base = project(anc_media, wall_now, anc_real, play_rate);
      c.ar = mcae_pkg::TIME_W'(wall_now);
      c.am = mcae_pkg::TIME_W'(base - longint'($urandom_range(fluct_win + 2)));
      if (c.am[mcae_pkg::TIME_W-1]) c.am = '0;
    end
    if ($urandom_range(99) < 70) c.mx = '1;
    else c.mx = mcae_pkg::TIME_W'(longint'({$urandom_range(32'h7FFF), $urandom}));
    if ($urandom_range(99) < 80) c.nr = mcae_pkg::RATE_W'($urandom_range(131072, 16384));
    else if ($urandom_range(9) == 0) c.nr = '0;
    if (anc_real != -1 && $urandom_range(99) < 80)
      c.tgt = mcae_pkg::TIME_W'(media_at(wall_now, 1'b1)
                                + longint'($urandom_range(400000)) - 200000);
    return c;
  endfunction

  task automatic add_row(cmd_t c, bit typed, res_t e);
    row_t w;
    w.c = c;
    w.typed = typed;
    w.e = e;
    rows.push_back(w);
  endtask

  task automatic send(cmd_t c, bit typed, res_t e);
    res_t r;
    if (idle_mode == 1 || idle_mode == 3)
      while ($urandom_range(99) < ((idle_mode == 1) ? 86 : 12)) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= c.func;
    in_tdata <= mcae_pkg::IN_DATA_W'({c.tgt, c.allow, c.nr, c.mx, c.ar, c.am, c.now});
    do @(posedge clk); while (!in_tready);
    r = predict(c);
    pending_results.push_back(typed ? e : r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic cfg_write(logic [mcae_pkg::CFG_AW-1:0] a, logic [mcae_pkg::TIME_W-1:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    if (a == mcae_pkg::CFG_START) start_clamp = longint'($signed(d));
    else fluct_win = d[mcae_pkg::WIN_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (idle_mode == 2) out_tready <= ($urandom_range(99) >= 86);
    else if (idle_mode == 3) out_tready <= ($urandom_range(99) >= 12);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    res_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, got %0d %h %h", $realtime, out_tuser,
                 out_tdata[mcae_pkg::TIME_W-1:0], out_tdata[mcae_pkg::TIME_W+:mcae_pkg::RATE_W]);
        n_errors++;
      end else begin
        x = pending_results.pop_front();
        if (x.status !== out_tuser || x.t !== out_tdata[mcae_pkg::TIME_W-1:0] ||
            x.rate !== out_tdata[mcae_pkg::TIME_W+:mcae_pkg::RATE_W]) begin
          $display("%0t: mismatch, expected status %0d time %h rate %h, got %0d %h %h",
                   $realtime, x.status, x.t, x.rate, out_tuser,
                   out_tdata[mcae_pkg::TIME_W-1:0],
                   out_tdata[mcae_pkg::TIME_W+:mcae_pkg::RATE_W]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #(60_000_000);
    $display("media_clock_anchor_engine regression: fail");
    $finish;
  end

  initial begin
    res_t   nr0, nr_rej, none;
    longint s_vals[4];
    int     w_vals[4];
    anc_media = -1;
    anc_real = -1;
    max_media = TMAXL;
    play_rate = mcae_pkg::RATE_ONE;
    start_clamp = -1;
    fluct_win = mcae_pkg::WIN_RESET;
    nr0 = '{mcae_pkg::ST_NO_ANCH, '0, mcae_pkg::RATE_ONE};
    nr_rej = '{mcae_pkg::ST_REJECTED, '0, mcae_pkg::RATE_ONE};
    none = '{mcae_pkg::ST_OK, '0, mcae_pkg::RATE_ONE};

    // directed table: typed rows are the plain cases after reset
    add_row(mk(mcae_pkg::FN_MEDIA_Q, 100, 0, 0, -1, 0, 0, 0), 1, nr0);
    add_row(mk(mcae_pkg::FN_REAL_Q, 100, 0, 0, -1, 0, 0, 500), 1, nr0);
    add_row(mk(3'd6, TMAXL, TMAXL, TMAXL, TMAXL, '1, 1, TMAXL), 1, none);
    add_row(mk(3'd7, TMINL, TMINL, TMINL, TMINL, 0, 0, TMINL), 1, none);
    add_row(mk(mcae_pkg::FN_UPDATE, 600, -1, 500, -1, 0, 0, 0), 1, nr_rej);
    add_row(mk(mcae_pkg::FN_UPDATE, 600, 1000, TMINL, -1, 0, 0, 0), 1, nr_rej);
    add_row(mk(mcae_pkg::FN_UPDATE, 600, 1000, 500, -1, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_MEDIA_Q, 700, 0, 0, -1, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_REAL_Q, 700, 0, 0, -1, 0, 0, 2000), 0, none);
    add_row(mk(mcae_pkg::FN_UPDATE, 800, 1100, 800, -1, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_UPDATE, 900, 0, 900, 50000, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_SET_MAX, 0, 0, 0, -1, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_MEDIA_Q, 5000, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_MEDIA_Q, TMAXL, 0, 0, 0, 0, 1, 0), 0, none);
    add_row(mk(mcae_pkg::FN_SET_MAX, 0, 0, 0, TMAXL, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_SET_RATE, 2000, 0, 0, 0, '1, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_MEDIA_Q, TMAXL, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_REAL_Q, TMINL, 0, 0, 0, 0, 0, TMINL), 0, none);
    add_row(mk(mcae_pkg::FN_REAL_Q, TMAXL, 0, 0, 0, 0, 0, TMAXL), 0, none);
    add_row(mk(mcae_pkg::FN_SET_RATE, -1, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_REAL_Q, 10, 0, 0, 0, 0, 0, 10), 0, none);
    add_row(mk(mcae_pkg::FN_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_SET_RATE, 50, 0, 0, 0, 1, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_UPDATE, 0, TMAXL, 0, -1, 0, 0, 0), 0, none);
    add_row(mk(mcae_pkg::FN_SET_RATE, 100, 0, 0, 0, mcae_pkg::RATE_ONE, 0, 0), 0, none);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].e);
    drain();

    s_vals = '{-1, 0, 140737488355327, 0};
    w_vals = '{0, 16777215, 10000, 0};
    for (int p = 0; p < N_PHASE; p++) begin
      idle_mode = p % 4;
      if (p > 0) begin
        if (p > 4) s_vals[3] = longint'($urandom_range(5000000));
        else s_vals[3] = -1;
        w_vals[3] = int'($urandom_range(16777215));
        cfg_write(mcae_pkg::CFG_START, mcae_pkg::TIME_W'(s_vals[p % 4]));
        cfg_write(mcae_pkg::CFG_WINDOW, mcae_pkg::TIME_W'(w_vals[(p + 1) % 4]));
      end
      for (int n = 0; n < N_RAND; n++) begin
        send(gen_cmd(), 0, none);
        // hold off until everything has come back
        if (n == N_RAND / 2) drain();
      end
      drain();
    end

    if (n_errors == 0) $display("media_clock_anchor_engine regression: pass");
    else $display("media_clock_anchor_engine regression: fail");
    $finish;
  end

endmodule
